@@ hdl/npcm_pkg.sv @@
// ----------------------------------------------------------------------------
// npcm_pkg
// Shared types and codes for the nearest palette color mapper: request
// command codes, field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package npcm_pkg;

   // Field widths fixed by the request and response formats
   localparam int CMD_W   = 2;
   localparam int IDX_W   = 8;
   localparam int CHAN_W  = 8;
   localparam int COLOR_W = 3 * CHAN_W;
   localparam int COUNT_W = 9;
   localparam int SQ_W    = 2 * CHAN_W;
   // Largest distance is 3 * 255^2, which fits in 18 bits
   localparam int DIST_W  = SQ_W + 2;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 8;
   localparam int RSP_USER_W = 2;

   // Request command codes (carried on req_tuser)
   typedef enum logic [CMD_W-1:0] {
      CMD_SRC_WRITE = 2'd0,
      CMD_TGT_WRITE = 2'd1,
      CMD_MAP_PIXEL = 2'd2,
      CMD_NONE      = 2'd3
   } cmd_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SCAN,
      ST_EMIT
   } state_type;

endpackage

@@ hdl/nearest_palette_color_mapper.sv @@
// ----------------------------------------------------------------------------
// nearest_palette_color_mapper
// Maps source palette indexes to the nearest target palette color by
// squared RGB distance, with a per-source-index result cache.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request: req_tuser is the command (write source entry,
//   write target entry, map pixel), req_tdata the slot, color and pixel.
//   Palette writes give no response. A map request gives
//   one response on rsp_*: the chosen index on rsp_tdata, flags on rsp_tuser.
//   csr_we/csr_wdata load target_count; do this only while the block is idle.
// Sequencing and throughput:
//   A cache hit, a pixel out of range or a zero count: the request passes
//   through ST_LOOKUP and ST_EMIT, and rsp_tvalid rises as req_tready returns.
//   A cache miss adds ST_SCAN over count entries. One distance unit (three 8x8
//   squares, then a sum and compare) takes one target entry per cycle from
//   the target palette memory's single read port, in a three-step pipeline.
//   The block takes no new request while a map is in flight.
// Reset and stall:
//   Reset clears the cache valid bits, target_count and the sequencer; the
//   palette and cache memories keep their contents; cache entries count as unwritten.
//   A response waiting on rsp_tready holds; palette writes are still taken
//   meanwhile, and a further map waits in its final state for the slot.
// ----------------------------------------------------------------------------
module nearest_palette_color_mapper
   import npcm_pkg::*;
#(
   parameter int SOURCE_ENTRIES = 256,
   parameter int TARGET_ENTRIES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] entry_index, [15:8] red, [23:16] green, [31:24] blue,
   // [39:32] pixel_in
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] command
   input  logic [CMD_W-1:0]      req_tuser,
   // Response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] pixel_out
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] remapped, [1] from_cache
   output logic [RSP_USER_W-1:0] rsp_tuser,
   // Register port: target_count
   input  logic                  csr_we,
   input  logic [COUNT_W-1:0]    csr_wdata
);

   localparam int SRC_AW = (SOURCE_ENTRIES > 1) ? $clog2(SOURCE_ENTRIES) : 1;
   localparam int TGT_AW = (TARGET_ENTRIES > 1) ? $clog2(TARGET_ENTRIES) : 1;
   localparam logic [COUNT_W-1:0] SRC_LIMIT = COUNT_W'(SOURCE_ENTRIES);
   localparam logic [COUNT_W-1:0] TGT_LIMIT = COUNT_W'(TARGET_ENTRIES);

   // Request fields
   logic [IDX_W-1:0]   req_slot;
   logic [COLOR_W-1:0] req_color;
   logic [IDX_W-1:0]   req_pixel;
   cmd_type            req_cmd;

   assign req_slot  = req_tdata[7:0];
   assign req_color = {req_tdata[15:8], req_tdata[23:16], req_tdata[31:24]};
   assign req_pixel = req_tdata[39:32];
   assign req_cmd   = cmd_type'(req_tuser);

   // Memories
   logic [COLOR_W-1:0] src_mem [SOURCE_ENTRIES];
   logic [COLOR_W-1:0] tgt_mem [TARGET_ENTRIES];
   logic [IDX_W-1:0]   cache_mem [SOURCE_ENTRIES];

   // State
   state_type             state_ff, state_in;
   logic [SOURCE_ENTRIES-1:0] valid_ff, valid_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]      pix_ff, pix_in;
   logic [COLOR_W-1:0]    src_color_ff, src_color_in;
   logic [COUNT_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                  v1_ff, v1_in;
   logic [IDX_W-1:0]      idx1_ff, idx1_in;
   logic                  v2_ff, v2_in;
   logic [IDX_W-1:0]      idx2_ff, idx2_in;
   logic [SQ_W-1:0]       sq_r_ff, sq_r_in;
   logic [SQ_W-1:0]       sq_g_ff, sq_g_in;
   logic [SQ_W-1:0]       sq_b_ff, sq_b_in;
   logic [DIST_W-1:0]     best_dist_ff, best_dist_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic [IDX_W-1:0]      res_pix_ff, res_pix_in;
   logic                  res_remap_ff, res_remap_in;
   logic                  res_cache_ff, res_cache_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]      rsp_pix_ff, rsp_pix_in;
   logic [RSP_USER_W-1:0] rsp_flags_ff, rsp_flags_in;

   // Memory read data and control
   logic [COLOR_W-1:0] src_rd_ff;
   logic [IDX_W-1:0]   cache_rd_ff;
   logic [COLOR_W-1:0] tgt_rd_ff;
   logic               src_we, tgt_we, cache_we;
   logic [TGT_AW-1:0]  tgt_rd_addr;

   // Helpers
   logic [COUNT_W-1:0] count_eff;
   logic               slot_src_ok, slot_tgt_ok, pix_ok;
   logic [CHAN_W-1:0]  d_r, d_g, d_b;
   logic [DIST_W-1:0]  sum_dist;

   assign count_eff   = (count_ff > TGT_LIMIT) ? TGT_LIMIT : count_ff;
   assign slot_src_ok = {1'b0, req_slot} < SRC_LIMIT;
   assign slot_tgt_ok = {1'b0, req_slot} < TGT_LIMIT;
   assign pix_ok      = {1'b0, pix_ff} < SRC_LIMIT;

   // Distance unit: absolute channel differences and squares
   always_comb begin
      d_r = (src_color_ff[23:16] > tgt_rd_ff[23:16]) ?
            src_color_ff[23:16] - tgt_rd_ff[23:16] : tgt_rd_ff[23:16] - src_color_ff[23:16];
      d_g = (src_color_ff[15:8] > tgt_rd_ff[15:8]) ?
            src_color_ff[15:8] - tgt_rd_ff[15:8] : tgt_rd_ff[15:8] - src_color_ff[15:8];
      d_b = (src_color_ff[7:0] > tgt_rd_ff[7:0]) ?
            src_color_ff[7:0] - tgt_rd_ff[7:0] : tgt_rd_ff[7:0] - src_color_ff[7:0];
      sq_r_in = SQ_W'(d_r) * SQ_W'(d_r);
      sq_g_in = SQ_W'(d_g) * SQ_W'(d_g);
      sq_b_in = SQ_W'(d_b) * SQ_W'(d_b);
   end

   // Distance unit: sum of squares
   assign sum_dist = DIST_W'(sq_r_ff) + DIST_W'(sq_g_ff) + DIST_W'(sq_b_ff);

   // Sequencer: next state and datapath control
   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      count_in     = count_ff;
      pix_in       = pix_ff;
      src_color_in = src_color_ff;
      rd_idx_in    = rd_idx_ff;
      v1_in        = 1'b0;
      idx1_in      = idx1_ff;
      v2_in        = v1_ff;
      idx2_in      = idx1_ff;
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      res_pix_in   = res_pix_ff;
      res_remap_in = res_remap_ff;
      res_cache_in = res_cache_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_pix_in   = rsp_pix_ff;
      rsp_flags_in = rsp_flags_ff;
      src_we       = 1'b0;
      tgt_we       = 1'b0;
      cache_we     = 1'b0;
      tgt_rd_addr  = rd_idx_ff[TGT_AW-1:0];
      req_tready   = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               pix_in = req_pixel;
               unique case (req_cmd)
                  CMD_SRC_WRITE: begin
                     if (slot_src_ok) begin
                        src_we   = 1'b1;
                        valid_in = '0;
                     end
                  end
                  CMD_TGT_WRITE: begin
                     if (slot_tgt_ok) begin
                        tgt_we   = 1'b1;
                        valid_in = '0;
                     end
                  end
                  CMD_MAP_PIXEL: state_in = ST_LOOKUP;
                  default: ;
               endcase
            end
         end

         // Source color and cache entry are ready; decide bypass, hit or scan
         ST_LOOKUP: begin
            if (!pix_ok || count_eff == '0) begin
               res_pix_in   = pix_ff;
               res_remap_in = 1'b0;
               res_cache_in = 1'b0;
               state_in     = ST_EMIT;
            end else if (valid_ff[pix_ff[SRC_AW-1:0]]) begin
               res_pix_in   = cache_rd_ff;
               res_remap_in = 1'b1;
               res_cache_in = 1'b1;
               state_in     = ST_EMIT;
            end else begin
               src_color_in = src_rd_ff;
               rd_idx_in    = '0;
               best_dist_in = '1;
               best_idx_in  = '0;
               state_in     = ST_SCAN;
            end
         end

         // Issue one target read per cycle; compare as results arrive
         ST_SCAN: begin
            if (rd_idx_ff < count_eff) begin
               v1_in     = 1'b1;
               idx1_in   = rd_idx_ff[IDX_W-1:0];
               rd_idx_in = rd_idx_ff + COUNT_W'(1);
            end
            if (v2_ff && sum_dist <= best_dist_ff) begin
               best_dist_in = sum_dist;
               best_idx_in  = idx2_ff;
            end
            if (rd_idx_ff == count_eff && !v1_ff && !v2_ff) begin
               cache_we                    = 1'b1;
               valid_in[pix_ff[SRC_AW-1:0]] = 1'b1;
               res_pix_in                  = best_idx_ff;
               res_remap_in                = 1'b1;
               res_cache_in                = 1'b0;
               state_in                    = ST_EMIT;
            end
         end

         // Hand the result to the output register once it is free
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in   = res_pix_ff;
               rsp_flags_in = {res_cache_ff, res_remap_ff};
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // Count write clears the whole cache
      if (csr_we) begin
         count_in = csr_wdata;
         valid_in = '0;
      end
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         count_ff     <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pix_ff       <= pix_in;
      src_color_ff <= src_color_in;
      rd_idx_ff    <= rd_idx_in;
      idx1_ff      <= idx1_in;
      idx2_ff      <= idx2_in;
      sq_r_ff      <= sq_r_in;
      sq_g_ff      <= sq_g_in;
      sq_b_ff      <= sq_b_in;
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
      res_pix_ff   <= res_pix_in;
      res_remap_ff <= res_remap_in;
      res_cache_ff <= res_cache_in;
      rsp_pix_ff   <= rsp_pix_in;
      rsp_flags_ff <= rsp_flags_in;
   end

   // Source palette and cache memories, read at request acceptance
   always_ff @(posedge clock) begin
      if (src_we) begin
         src_mem[req_slot[SRC_AW-1:0]] <= req_color;
      end
      if (cache_we) begin
         cache_mem[pix_ff[SRC_AW-1:0]] <= best_idx_ff;
      end
      src_rd_ff   <= src_mem[req_pixel[SRC_AW-1:0]];
      cache_rd_ff <= cache_mem[req_pixel[SRC_AW-1:0]];
   end

   // Target palette memory
   always_ff @(posedge clock) begin
      if (tgt_we) begin
         tgt_mem[req_slot[TGT_AW-1:0]] <= req_color;
      end
      tgt_rd_ff <= tgt_mem[tgt_rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pix_ff;
   assign rsp_tuser  = rsp_flags_ff;

endmodule

@@ hdl/npcm_checker.sv @@
// ----------------------------------------------------------------------------
// npcm_checker
// Port-level checks for the nearest palette color mapper, bound to the top.
// ----------------------------------------------------------------------------
module npcm_port_checker
   import npcm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [CMD_W-1:0]      req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser,
   input logic                  csr_we,
   input logic [COUNT_W-1:0]    csr_wdata
);

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // A cached result is always a remapped one
   a_cache_implies_remap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("from_cache without remapped");

   // A map request occupies the block for at least the next cycle
   a_map_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == CMD_MAP_PIXEL |=> !req_tready)
      else $error("request taken during a map");

   // No response comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind nearest_palette_color_mapper npcm_port_checker u_npcm_port_checker (.*);
